// ===== rtl/icsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsh_pkg
// shared types and constants for the image channel statistics histogram
// ----------------------------------------------------------------------------
package icsh_pkg;

    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 17;
    localparam int NUM_CHAN = 4;

    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_BIN     = 2'd1;
    localparam logic [1:0] REQ_SUMMARY = 2'd2;
    localparam logic [1:0] REQ_START   = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] CODE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] CODE_MIN = 24'sh800000;

    // divider request from the top level to the shared divider
    typedef struct packed {
        logic        start;
        logic        negate;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

endpackage : icsh_pkg
`default_nettype wire

// ===== rtl/image_channel_stats_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_channel_stats_histogram
// per-image rgba min/max/sum and rgb histograms with fraction queries
// ----------------------------------------------------------------------------
// four channel lanes work side by side on each pixel; red, green and blue
// lanes each own a BIN_COUNT-entry histogram memory updated through a
// three-stage read-modify-write pipe with forwarding, so pixels stream
// back to back while no clearing pass or query runs. a start request,
// and reset, launch a clearing pass over every histogram entry; no
// request is taken during it. a bin read waits for the pixel pipe to
// drain, reads the three memories, then runs three divisions in turn on
// the shared serial divider. a summary read runs one division. results
// sit in an output register, so the next pixel or start request is
// taken while one waits; a query waits for it to drain.
// ----------------------------------------------------------------------------
module image_channel_stats_histogram #(
    parameter int BIN_COUNT  = 256,
    parameter int MAX_PIXELS = 4194304,
    parameter int HDR_SHIFT  = 3
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_wdata,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  req_type,
    input  wire  signed [23:0] sample_red,
    input  wire  signed [23:0] sample_green,
    input  wire  signed [23:0] sample_blue,
    input  wire  signed [23:0] sample_alpha,
    input  wire  [7:0]  query_index,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [16:0] hist_red,
    output logic [16:0] hist_green,
    output logic [16:0] hist_blue,
    output logic signed [23:0] chan_min,
    output logic signed [23:0] chan_max,
    output logic signed [23:0] chan_avg,
    output logic        count_overflow
);
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = CNT_W + 23;
    localparam int AW    = $clog2(BIN_COUNT);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic       hdr_reg;
    logic [CNT_W-1:0] total_reg;
    logic       ovf_reg;
    logic [1:0] step_reg;       // which division is running
    logic       is_bin_reg, inrange_reg;
    logic [1:0] chan_reg;
    logic [AW-1:0] addr_reg;
    logic       out_full_reg;

    logic [16:0] h_reg [3];
    logic signed [23:0] mn_reg, mx_reg, av_reg;

    logic accept, pix_acc, clr;
    logic [3:0] busy;
    logic [3:0] clearing;
    logic [CNT_W-1:0] rd_cnt [4];
    logic signed [23:0] mn [4], mx [4];
    logic signed [SUM_W-1:0] sm [4];
    logic signed [23:0] smp [4];

    icsh_pkg::div_req_t dreq;
    logic [63:0] dq;
    logic        ddone;

    assign smp[0] = sample_red;
    assign smp[1] = sample_green;
    assign smp[2] = sample_blue;
    assign smp[3] = sample_alpha;

    // pixels stream while idle and no clearing pass runs; starts and
    // queries wait for the lanes to settle, queries also for the output
    // register to be free
    always_comb
    begin
        in_ready = 1'b0;
        if (state_reg == ST_IDLE)
        begin
            if (req_type == icsh_pkg::REQ_PIXEL)
                in_ready = (clearing == 4'd0);
            else if (req_type == icsh_pkg::REQ_START)
                in_ready = (busy == 4'd0);
            else
                in_ready = (busy == 4'd0) && !out_full_reg;
        end
    end

    assign accept  = in_valid && in_ready;
    assign clr     = accept && req_type == icsh_pkg::REQ_START;
    assign pix_acc = accept && req_type == icsh_pkg::REQ_PIXEL
                     && total_reg != CNT_W'(MAX_PIXELS);

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            icsh_lane #(
                .BIN_COUNT (BIN_COUNT),
                .HDR_SHIFT (HDR_SHIFT),
                .CNT_W     (CNT_W),
                .SUM_W     (SUM_W),
                .HAS_HIST  (g < 3)
            ) u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .hdr_mode (hdr_reg),
                .clr      (clr),
                .pix      (pix_acc),
                .sample   (smp[g]),
                .rd_addr  (addr_reg),
                .rd_count (rd_cnt[g]),
                .min_val  (mn[g]),
                .max_val  (mx[g]),
                .sum_val  (sm[g]),
                .busy     (busy[g]),
                .clearing (clearing[g])
            );
        end
    endgenerate

    icsh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .quot  (dq),
        .done  (ddone)
    );

    // divider launch: bin fractions or the channel average
    logic [CNT_W-1:0] cnt_sel;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0] sum_mag;
    always_comb
    begin
        cnt_sel = rd_cnt[step_reg];
        sum_sel = sm[chan_reg];
        sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
        dreq.start    = (state_reg == ST_DIV);
        dreq.negate   = !is_bin_reg && sum_sel[SUM_W-1];
        dreq.divisor  = 32'(total_reg);
        dreq.dividend = is_bin_reg ? (64'(cnt_sel) << 16) : 64'(sum_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            hdr_reg      <= 1'b0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            out_full_reg <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            if (cfg_we) hdr_reg <= cfg_wdata;
            if (out_valid && out_ready) out_full_reg <= 1'b0;
            if (clr)
            begin
                total_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (accept && req_type == icsh_pkg::REQ_PIXEL)
            begin
                if (pix_acc) total_reg <= total_reg + 1'b1;
                else         ovf_reg   <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (accept && (req_type == icsh_pkg::REQ_BIN
                                   || req_type == icsh_pkg::REQ_SUMMARY))
                        state_reg <= ST_RD;
                end
                ST_RD:   state_reg <= ST_DIV;   // memory read latency
                ST_DIV:  state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (ddone)
                    begin
                        if (is_bin_reg) h_reg[step_reg] <= 17'(dq);
                        else            av_reg <= 24'(dq);
                        if (is_bin_reg && step_reg != 2'd2)
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= ST_DIV;
                        end
                        else
                            state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    out_full_reg <= 1'b1;
                    state_reg    <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // query capture and summary fields
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            is_bin_reg  <= req_type == icsh_pkg::REQ_BIN;
            addr_reg    <= AW'(query_index);
            chan_reg    <= query_index[1:0];
            inrange_reg <= (req_type == icsh_pkg::REQ_BIN)
                           ? ({24'd0, query_index} < 32'(BIN_COUNT))
                           : (query_index < 8'd4);
        end
        if (state_reg == ST_RD)
        begin
            mn_reg <= mn[chan_reg];
            mx_reg <= mx[chan_reg];
        end
    end

    logic live;
    assign live = inrange_reg && total_reg != '0;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            hist_red       <= (is_bin_reg && live) ? h_reg[0] : '0;
            hist_green     <= (is_bin_reg && live) ? h_reg[1] : '0;
            hist_blue      <= (is_bin_reg && live) ? h_reg[2] : '0;
            chan_min       <= (!is_bin_reg && live) ? mn_reg : '0;
            chan_max       <= (!is_bin_reg && live) ? mx_reg : '0;
            chan_avg       <= (!is_bin_reg && live) ? av_reg : '0;
            count_overflow <= ovf_reg;
        end
    end

    assign out_valid = out_full_reg;

    // no request is taken while a query is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("request accepted during query");
    // pixel count never passes its limit
    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count overran");
    // a division completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        ddone |-> state_reg == ST_WAIT)
        else $error("unexpected divider completion");
endmodule : image_channel_stats_histogram
`default_nettype wire

// ===== rtl/icsh_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsh_lane
// one channel lane: running min, max and sum, optional histogram memory
// ----------------------------------------------------------------------------
module icsh_lane #(
    parameter int BIN_COUNT = 256,
    parameter int HDR_SHIFT = 3,
    parameter int CNT_W     = 23,
    parameter int SUM_W     = 46,
    parameter bit HAS_HIST  = 1'b1
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    hdr_mode,
    input  wire                                    clr,
    input  wire                                    pix,
    input  wire signed [icsh_pkg::SAMPLE_W-1:0]    sample,
    input  wire [$clog2(BIN_COUNT)-1:0]            rd_addr,
    output logic [CNT_W-1:0]                       rd_count,
    output logic signed [icsh_pkg::SAMPLE_W-1:0]   min_val,
    output logic signed [icsh_pkg::SAMPLE_W-1:0]   max_val,
    output logic signed [SUM_W-1:0]                sum_val,
    output logic                                   busy,
    output logic                                   clearing
);
    localparam int AW    = $clog2(BIN_COUNT);
    localparam int FULLW = 17 + HDR_SHIFT;
    localparam int PW    = FULLW + 11;

    logic signed [icsh_pkg::SAMPLE_W-1:0] min_reg, max_reg;
    logic signed [SUM_W-1:0]              sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= icsh_pkg::CODE_MAX;
            max_reg <= icsh_pkg::CODE_MIN;
            sum_reg <= '0;
        end
        else if (clr)
        begin
            min_reg <= icsh_pkg::CODE_MAX;
            max_reg <= icsh_pkg::CODE_MIN;
            sum_reg <= '0;
        end
        else if (pix)
        begin
            if (sample < min_reg) min_reg <= sample;
            if (sample > max_reg) max_reg <= sample;
            sum_reg <= sum_reg + SUM_W'(sample);
        end
    end

    assign min_val = min_reg;
    assign max_val = max_reg;
    assign sum_val = sum_reg;

    generate
        if (HAS_HIST)
        begin : g_hist
            logic [CNT_W-1:0] mem [BIN_COUNT];
            logic [FULLW-1:0] full, clamp;
            logic [PW-1:0]    prod;
            logic [AW-1:0]    bin_s1_reg, bin_s2_reg, clr_addr_reg;
            logic             v_s1_reg, v_s2_reg, clearing_reg;
            logic [CNT_W-1:0] cnt_s2_reg;
            logic             fwd;

            // clamp then scale by bin count minus one
            always_comb
            begin
                full  = hdr_mode ? (FULLW'(1) << (16 + HDR_SHIFT)) : (FULLW'(1) << 16);
                clamp = '0;
                if (!sample[icsh_pkg::SAMPLE_W-1] && sample != '0)
                    clamp = (sample > $signed(icsh_pkg::SAMPLE_W'(full)))
                            ? full : FULLW'(sample);
                prod = PW'(clamp) * PW'(BIN_COUNT - 1);
            end

            // stage 1: bin index; stage 2: read count; stage 3: write back
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_s1_reg     <= 1'b0;
                    v_s2_reg     <= 1'b0;
                    clearing_reg <= 1'b1;
                    clr_addr_reg <= '0;
                end
                else
                begin
                    v_s1_reg <= pix && !clr;
                    v_s2_reg <= v_s1_reg && !clr;
                    if (clr)
                    begin
                        clearing_reg <= 1'b1;
                        clr_addr_reg <= '0;
                    end
                    else if (clearing_reg)
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                        if (clr_addr_reg == AW'(BIN_COUNT - 1)) clearing_reg <= 1'b0;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                bin_s1_reg <= hdr_mode ? AW'(prod >> (16 + HDR_SHIFT)) : AW'(prod >> 16);
                bin_s2_reg <= bin_s1_reg;
                cnt_s2_reg <= fwd ? cnt_s2_reg + 1'b1 : mem[bin_s1_reg];
                if (clearing_reg)
                    mem[clr_addr_reg] <= '0;
                else if (v_s2_reg)
                    mem[bin_s2_reg] <= cnt_s2_reg + 1'b1;
                rd_count <= mem[rd_addr];
            end

            assign fwd      = v_s2_reg && (bin_s2_reg == bin_s1_reg);
            assign busy     = clearing_reg || v_s1_reg || v_s2_reg;
            assign clearing = clearing_reg;
        end
        else
        begin : g_nohist
            assign rd_count = '0;
            assign busy     = 1'b0;
            assign clearing = 1'b0;
        end
    endgenerate
endmodule : icsh_lane
`default_nettype wire

// ===== rtl/icsh_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsh_div
// radix-2 restoring divider, one quotient bit per cycle, magnitude in
// ----------------------------------------------------------------------------
module icsh_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire icsh_pkg::div_req_t req,
    output logic [63:0]          quot,
    output logic                 done
);
    logic [63:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [6:0]  n_reg;
    logic        run_reg, neg_reg;
    logic [32:0] trial;

    assign trial = {r_reg[31:0], q_reg[63]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            n_reg   <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                n_reg   <= 7'd64;
            end
            else if (run_reg)
            begin
                n_reg <= n_reg - 1'b1;
                if (n_reg == 7'd1)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            d_reg   <= req.divisor;
            r_reg   <= '0;
            neg_reg <= req.negate;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so 32 bits hold it
            if (!trial[32])
                r_reg <= trial[31:0];
            else
                r_reg <= {r_reg[30:0], q_reg[63]};
            q_reg <= {q_reg[62:0], ~trial[32]};
        end
    end

    assign quot = neg_reg ? (~q_reg + 64'd1) : q_reg;
endmodule : icsh_div
`default_nettype wire

// ===== verif/image_channel_stats_histogram_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_channel_stats_histogram_tb
// streams pixel, bin read, summary read and start requests into the block,
// predicts every query answer from its own copy of the statistics and checks
// each answer field by field, over both binning modes and several idle mixes
// ----------------------------------------------------------------------------

// one query answer, predicted or observed
typedef struct {
    logic [16:0]        hr;
    logic [16:0]        hg;
    logic [16:0]        hb;
    logic signed [23:0] mn;
    logic signed [23:0] mx;
    logic signed [23:0] av;
    logic               ovf;
} answer_t;

// holds the running statistics and the queue of predicted query answers
class stats_scoreboard;

    int                 pix_limit;
    bit                 hdr;
    int unsigned        bins_r[256];
    int unsigned        bins_g[256];
    int unsigned        bins_b[256];
    logic signed [23:0] ch_min[4];
    logic signed [23:0] ch_max[4];
    longint             ch_sum[4];
    int unsigned        total;
    bit                 ovf_seen;
    answer_t            answers_due[$];
    int                 errors;

    function new(int limit);
        pix_limit = limit;
        hdr       = 0;
        errors    = 0;
        clear();
    endfunction

    function void clear();
        for (int i = 0; i < 256; i++)
        begin
            bins_r[i] = 0;
            bins_g[i] = 0;
            bins_b[i] = 0;
        end
        for (int k = 0; k < 4; k++)
        begin
            ch_min[k] = icsh_pkg::CODE_MAX;
            ch_max[k] = icsh_pkg::CODE_MIN;
            ch_sum[k] = 0;
        end
        total    = 0;
        ovf_seen = 0;
    endfunction

    function int bin_of(logic signed [23:0] v);
        int     s;
        longint full;
        longint c;
        s    = hdr ? 3 : 0;
        full = longint'(65536) << s;
        if (v <= 0)
            return 0;
        c = longint'(v);
        if (c > full)
            c = full;
        return int'((c * 255) >>> (16 + s));
    endfunction

    function logic [16:0] frac(int unsigned cnt);
        longint q;
        if (total == 0)
            return 17'd0;
        q = (longint'(cnt) << 16) / longint'(total);
        return q[16:0];
    endfunction

    function int pending();
        return answers_due.size();
    endfunction

    function void note_request(logic [1:0] req, logic signed [23:0] r,
                               logic signed [23:0] g, logic signed [23:0] b,
                               logic signed [23:0] a, logic [7:0] q);
        answer_t            ans;
        logic signed [23:0] p[4];
        longint             avg;
        if (req == icsh_pkg::REQ_START)
        begin
            clear();
            return;
        end
        if (req == icsh_pkg::REQ_PIXEL)
        begin
            if (total >= pix_limit)
            begin
                ovf_seen = 1;
                return;
            end
            p[0] = r; p[1] = g; p[2] = b; p[3] = a;
            for (int k = 0; k < 4; k++)
            begin
                if (p[k] < ch_min[k])
                    ch_min[k] = p[k];
                if (p[k] > ch_max[k])
                    ch_max[k] = p[k];
                ch_sum[k] += longint'(p[k]);
            end
            bins_r[bin_of(r)]++;
            bins_g[bin_of(g)]++;
            bins_b[bin_of(b)]++;
            total++;
            return;
        end
        ans = '{17'd0, 17'd0, 17'd0, 24'sd0, 24'sd0, 24'sd0, ovf_seen};
        if (req == icsh_pkg::REQ_BIN)
        begin
            ans.hr = frac(bins_r[q]);
            ans.hg = frac(bins_g[q]);
            ans.hb = frac(bins_b[q]);
        end
        else if (q < 4 && total != 0)
        begin
            avg    = ch_sum[q] / longint'(total);
            ans.mn = ch_min[q];
            ans.mx = ch_max[q];
            ans.av = avg[23:0];
        end
        answers_due.insert(answers_due.size(), ans);
    endfunction

    function void check_result(answer_t got);
        answer_t want;
        if (answers_due.size() == 0)
        begin
            $error("unexpected result, nothing pending");
            errors++;
            return;
        end
        want = answers_due[0];
        answers_due.delete(0);
        if (got.hr !== want.hr)
        begin
            $error("hist_red expected %0d actual %0d", want.hr, got.hr);
            errors++;
        end
        if (got.hg !== want.hg)
        begin
            $error("hist_green expected %0d actual %0d", want.hg, got.hg);
            errors++;
        end
        if (got.hb !== want.hb)
        begin
            $error("hist_blue expected %0d actual %0d", want.hb, got.hb);
            errors++;
        end
        if (got.mn !== want.mn)
        begin
            $error("chan_min expected %0d actual %0d", want.mn, got.mn);
            errors++;
        end
        if (got.mx !== want.mx)
        begin
            $error("chan_max expected %0d actual %0d", want.mx, got.mx);
            errors++;
        end
        if (got.av !== want.av)
        begin
            $error("chan_avg expected %0d actual %0d", want.av, got.av);
            errors++;
        end
        if (got.ovf !== want.ovf)
        begin
            $error("count_overflow expected %0d actual %0d", want.ovf, got.ovf);
            errors++;
        end
    endfunction

endclass

module image_channel_stats_histogram_tb;

    // pixel limit of the default build
    localparam int PIX_LIMIT = 4194304;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic signed [23:0] sample_red;
    logic signed [23:0] sample_green;
    logic signed [23:0] sample_blue;
    logic signed [23:0] sample_alpha;
    logic [7:0]         query_index;
    logic               out_valid;
    logic               out_ready;
    logic [16:0]        hist_red;
    logic [16:0]        hist_green;
    logic [16:0]        hist_blue;
    logic signed [23:0] chan_min;
    logic signed [23:0] chan_max;
    logic signed [23:0] chan_avg;
    logic               count_overflow;

    // idle mix of the current phase, in percent
    int idle_pct;
    int stall_pct;
    // cycles the receiver still holds off for the backpressure test
    int hold_left;

    stats_scoreboard sb;

    image_channel_stats_histogram #(
        .BIN_COUNT  (256),
        .MAX_PIXELS (PIX_LIMIT),
        .HDR_SHIFT  (3)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .sample_red     (sample_red),
        .sample_green   (sample_green),
        .sample_blue    (sample_blue),
        .sample_alpha   (sample_alpha),
        .query_index    (query_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hist_red       (hist_red),
        .hist_green     (hist_green),
        .hist_blue      (hist_blue),
        .chan_min       (chan_min),
        .chan_max       (chan_max),
        .chan_avg       (chan_avg),
        .count_overflow (count_overflow)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // one request: optional idle gap, then hold valid until the handshake
    task automatic send_req(logic [1:0] req, logic signed [23:0] r,
                            logic signed [23:0] g, logic signed [23:0] b,
                            logic signed [23:0] a, logic [7:0] q);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        sample_red   <= r;
        sample_green <= g;
        sample_blue  <= b;
        sample_alpha <= a;
        query_index  <= q;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(req, r, g, b, a, q);
    endtask

    task automatic send_pixel(logic signed [23:0] r, logic signed [23:0] g,
                              logic signed [23:0] b, logic signed [23:0] a);
        send_req(icsh_pkg::REQ_PIXEL, r, g, b, a, 8'd0);
    endtask

    // query and start requests carry random junk in the sample fields
    task automatic send_ctl(logic [1:0] req, logic [7:0] q);
        send_req(req, 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), q);
    endtask

    // drop valid, let every answer come back, then let the pixel pipe
    // and any clearing pass finish before touching the register
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_hdr(bit v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.hdr = v;
    endtask

    // samples weighted toward the binning ranges, with extremes and noise
    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(9))
            0:       return 24'($urandom);
            1:       return icsh_pkg::CODE_MAX;
            2:       return icsh_pkg::CODE_MIN;
            3:       return 24'($urandom_range(65536));
            4:       return 24'($urandom_range(524388));
            5:       return -24'sd1 - 24'($urandom_range(70000));
            default: return 24'($urandom_range(600000));
        endcase
    endfunction

    function automatic logic [7:0] summary_index();
        // mostly real channels, sometimes out of range
        return ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    endfunction

    // one image: start, then pixels with queries and occasional starts mixed in
    task automatic run_image(int n_items);
        send_ctl(icsh_pkg::REQ_START, 8'($urandom));
        for (int i = 0; i < n_items; i++)
        begin
            case ($urandom_range(19))
                0, 1:    send_ctl(icsh_pkg::REQ_BIN, 8'($urandom));
                2:       send_ctl(icsh_pkg::REQ_SUMMARY, summary_index());
                3:       if ($urandom_range(3) == 0)
                             send_ctl(icsh_pkg::REQ_START, 8'($urandom));
                         else
                             send_ctl(icsh_pkg::REQ_BIN, 8'($urandom_range(255, 250)));
                default: send_pixel(rand_sample(), rand_sample(),
                                    rand_sample(), rand_sample());
            endcase
        end
        // close each image with a summary read and a bin read
        send_ctl(icsh_pkg::REQ_SUMMARY, 8'($urandom_range(3)));
        send_ctl(icsh_pkg::REQ_BIN, 8'($urandom));
    endtask

    // receiver: check answers, drive ready from the stall mix or the hold
    initial
    begin
        answer_t got;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = '{hist_red, hist_green, hist_blue, chan_min, chan_max,
                        chan_avg, count_overflow};
                sb.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // main sequence
    initial
    begin
        sb           = new(PIX_LIMIT);
        idle_pct     = 0;
        stall_pct    = 0;
        hold_left    = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        in_valid     = 1'b0;
        req_type     = icsh_pkg::REQ_PIXEL;
        sample_red   = '0;
        sample_green = '0;
        sample_blue  = '0;
        sample_alpha = '0;
        query_index  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty image queries, then the edges of the sample range
        write_hdr(1'b0);
        send_ctl(icsh_pkg::REQ_BIN, 8'd0);
        send_ctl(icsh_pkg::REQ_SUMMARY, 8'd1);
        send_pixel(icsh_pkg::CODE_MAX, icsh_pkg::CODE_MIN, 24'sd0, 24'sd65536);
        send_pixel(24'sd65535, 24'sd65536, 24'sd65537, icsh_pkg::CODE_MIN);
        send_pixel(icsh_pkg::CODE_MIN, 24'sd524288, icsh_pkg::CODE_MAX,
                   icsh_pkg::CODE_MAX);
        send_pixel(-24'sd1, 24'sd257, 24'sd32768, 24'sd0);
        send_ctl(icsh_pkg::REQ_BIN, 8'd0);
        send_ctl(icsh_pkg::REQ_BIN, 8'd255);
        send_ctl(icsh_pkg::REQ_BIN, 8'd127);
        for (int k = 0; k < 4; k++)
            send_ctl(icsh_pkg::REQ_SUMMARY, 8'(k));
        send_ctl(icsh_pkg::REQ_SUMMARY, 8'd4);
        send_ctl(icsh_pkg::REQ_SUMMARY, 8'd255);
        send_ctl(icsh_pkg::REQ_START, 8'd0);
        send_ctl(icsh_pkg::REQ_SUMMARY, 8'd0);

        // hdr binning with the same edges
        write_hdr(1'b1);
        send_pixel(24'sd524288, 24'sd524289, 24'sd65536, 24'sd1);
        send_pixel(icsh_pkg::CODE_MAX, 24'sd262144, icsh_pkg::CODE_MIN, -24'sd5);
        send_ctl(icsh_pkg::REQ_BIN, 8'd255);
        send_ctl(icsh_pkg::REQ_BIN, 8'd31);
        send_ctl(icsh_pkg::REQ_SUMMARY, 8'd3);

        // random images over the idle mixes and both modes
        idle_pct = 0;  stall_pct = 0;
        run_image(60);
        idle_pct = 82; stall_pct = 0;
        run_image(60);
        write_hdr(1'b0);
        idle_pct = 0;  stall_pct = 82;
        run_image(60);
        idle_pct = 32; stall_pct = 32;
        run_image(60);
        write_hdr(1'b1);
        idle_pct = 0;  stall_pct = 0;
        run_image(50);
        idle_pct = 32; stall_pct = 32;
        run_image(50);

        // backpressure: receiver holds off while queries keep coming, so
        // the output register fills and the input stalls
        settle();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 3000;
        for (int i = 0; i < 6; i++)
        begin
            send_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
            send_ctl(icsh_pkg::REQ_SUMMARY, 8'($urandom_range(3)));
        end

        // fresh image after the pressure test
        write_hdr(1'b0);
        send_ctl(icsh_pkg::REQ_START, 8'd0);
        send_ctl(icsh_pkg::REQ_SUMMARY, 8'd2);

        settle();
        if (sb.errors == 0)
            $display("image_channel_stats_histogram_tb: done, clean");
        else
            $display("image_channel_stats_histogram_tb: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("image_channel_stats_histogram_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/icsh_pkg.sv
rtl/icsh_lane.sv
rtl/icsh_div.sv
rtl/image_channel_stats_histogram.sv
verif/image_channel_stats_histogram_tb.sv
